// ===== src/smm_pkg.sv =====
package smm_pkg;

    localparam int DATA_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 36;
    localparam int IDX_W  = 3;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic first;
    } mac_ctrl_t;

endpackage

// ===== src/small_matrix_multiply_top.sv =====
// Loading: one element per cycle, s_ready high while elements are taken.
// Compute: one shared 16x16 multiplier and 36-bit accumulator; each inner term goes through
// store read, multiply and accumulate.
// Results follow in row-major order; s_ready stays low until the last is taken.
// Reset (aresetn low, synchronous) clears the load position and sequencer; stores are not.
module small_matrix_multiply_top #(
    parameter int ROWS_A    = 4,
    parameter int INNER_DIM = 5,
    parameter int COLS_B    = 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [smm_pkg::DATA_W-1:0]  s_element_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [smm_pkg::ACC_W-1:0]   m_product_value,
    output logic [smm_pkg::IDX_W-1:0]          m_out_row,
    output logic [smm_pkg::IDX_W-1:0]          m_out_col,
    output logic                               m_last_result
);

    localparam int A_SIZE     = ROWS_A * INNER_DIM;
    localparam int B_SIZE     = INNER_DIM * COLS_B;
    localparam int LOAD_TOTAL = A_SIZE + B_SIZE;
    localparam int AW         = (A_SIZE > 1) ? $clog2(A_SIZE) : 1;
    localparam int BW         = (B_SIZE > 1) ? $clog2(B_SIZE) : 1;
    localparam int LW         = $clog2(LOAD_TOTAL);
    localparam int IW         = smm_pkg::IDX_W;

    smm_pkg::state_t    state_reg, state_next;
    smm_pkg::mac_ctrl_t mac_ctrl;

    logic [LW-1:0] load_count_reg;
    logic [LW-1:0] b_offset;
    logic [IW-1:0] row_reg, col_reg, k_reg;
    logic [AW-1:0] a_addr_reg, a_base_reg;
    logic [BW-1:0] b_addr_reg;

    logic s_fire, m_fire, load_done, k_done, is_last, in_a;
    logic signed [smm_pkg::DATA_W-1:0] a_rdata, b_rdata;

    assign s_fire    = s_valid && s_ready;
    assign m_fire    = m_valid && m_ready;
    assign load_done = (load_count_reg == LW'(LOAD_TOTAL - 1));
    assign k_done    = (k_reg == IW'(INNER_DIM - 1));
    assign is_last   = (row_reg == IW'(ROWS_A - 1)) && (col_reg == IW'(COLS_B - 1));
    assign in_a      = (load_count_reg < LW'(A_SIZE));
    assign b_offset  = load_count_reg - LW'(A_SIZE);

    smm_mem #(.DEPTH(A_SIZE), .AW(AW)) u_a_mem (
        .aclk  (aclk),
        .we    (s_fire && in_a),
        .waddr (load_count_reg[AW-1:0]),
        .wdata (s_element_value),
        .raddr (a_addr_reg),
        .rdata (a_rdata)
    );

    smm_mem #(.DEPTH(B_SIZE), .AW(BW)) u_b_mem (
        .aclk  (aclk),
        .we    (s_fire && !in_a),
        .waddr (b_offset[BW-1:0]),
        .wdata (s_element_value),
        .raddr (b_addr_reg),
        .rdata (b_rdata)
    );

    smm_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .a_in (a_rdata),
        .b_in (b_rdata),
        .acc  (m_product_value)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smm_pkg::ST_LOAD: if (s_fire && load_done) state_next = smm_pkg::ST_READ;
            smm_pkg::ST_READ: state_next = smm_pkg::ST_MUL;
            smm_pkg::ST_MUL:  state_next = smm_pkg::ST_ACC;
            smm_pkg::ST_ACC:  state_next = k_done ? smm_pkg::ST_OUT : smm_pkg::ST_READ;
            smm_pkg::ST_OUT: begin
                if (m_fire) begin
                    state_next = is_last ? smm_pkg::ST_LOAD : smm_pkg::ST_READ;
                end
            end
            default: state_next = smm_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        s_ready         = 1'b0;
        m_valid         = 1'b0;
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.acc_en = 1'b0;
        mac_ctrl.first  = (k_reg == '0);
        case (state_reg)
            smm_pkg::ST_LOAD: s_ready         = 1'b1;
            smm_pkg::ST_MUL:  mac_ctrl.mul_en = 1'b1;
            smm_pkg::ST_ACC:  mac_ctrl.acc_en = 1'b1;
            smm_pkg::ST_OUT:  m_valid         = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= smm_pkg::ST_LOAD;
            load_count_reg <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            k_reg          <= '0;
            a_addr_reg     <= '0;
            a_base_reg     <= '0;
            b_addr_reg     <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                smm_pkg::ST_LOAD: begin
                    if (s_fire) begin
                        if (load_done) begin
                            load_count_reg <= '0;
                            row_reg        <= '0;
                            col_reg        <= '0;
                            k_reg          <= '0;
                            a_addr_reg     <= '0;
                            a_base_reg     <= '0;
                            b_addr_reg     <= '0;
                        end else begin
                            load_count_reg <= load_count_reg + 1'b1;
                        end
                    end
                end
                smm_pkg::ST_ACC: begin
                    if (!k_done) begin
                        k_reg      <= k_reg + 1'b1;
                        a_addr_reg <= a_addr_reg + 1'b1;
                        b_addr_reg <= b_addr_reg + BW'(COLS_B);
                    end
                end
                smm_pkg::ST_OUT: begin
                    if (m_fire && !is_last) begin
                        k_reg <= '0;
                        if (col_reg == IW'(COLS_B - 1)) begin
                            col_reg    <= '0;
                            row_reg    <= row_reg + 1'b1;
                            a_base_reg <= a_base_reg + AW'(INNER_DIM);
                            a_addr_reg <= a_base_reg + AW'(INNER_DIM);
                            b_addr_reg <= '0;
                        end else begin
                            col_reg    <= col_reg + 1'b1;
                            a_addr_reg <= a_base_reg;
                            b_addr_reg <= BW'(col_reg + 1'b1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_out_row     = row_reg;
    assign m_out_col     = col_reg;
    assign m_last_result = is_last;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channels active together");

    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(k_reg) < INNER_DIM)
        else $error("inner index out of range");

    a_load_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(load_count_reg) < LOAD_TOTAL)
        else $error("load position out of range");

    a_last_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_last_result) |=> s_ready)
        else $error("block not ready after final result");
`endif

endmodule

// ===== src/smm_mem.sv =====
module smm_mem #(
    parameter int DEPTH = 20,
    parameter int AW    = 5
) (
    input  logic                               aclk,
    input  logic                               we,
    input  logic [AW-1:0]                      waddr,
    input  logic signed [smm_pkg::DATA_W-1:0]  wdata,
    input  logic [AW-1:0]                      raddr,
    output logic signed [smm_pkg::DATA_W-1:0]  rdata
);

    logic signed [smm_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [smm_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/smm_mac.sv =====
module smm_mac (
    input  logic                               aclk,
    input  smm_pkg::mac_ctrl_t                 ctrl,
    input  logic signed [smm_pkg::DATA_W-1:0]  a_in,
    input  logic signed [smm_pkg::DATA_W-1:0]  b_in,
    output logic signed [smm_pkg::ACC_W-1:0]   acc
);

    logic signed [smm_pkg::PROD_W-1:0] prod_reg;
    logic signed [smm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [smm_pkg::ACC_W-1:0]  acc_next;
    logic signed [smm_pkg::ACC_W-1:0]  prod_ext;

    assign prod_ext = {{(smm_pkg::ACC_W - smm_pkg::PROD_W){prod_reg[smm_pkg::PROD_W-1]}},
                       prod_reg};
    assign acc_next = (ctrl.first ? '0 : acc_reg) + prod_ext;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= a_in * b_in;
        end
        if (ctrl.acc_en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== verif/testbench.sv =====
module testbench;

    localparam int ROWS_A    = 4;
    localparam int INNER_DIM = 5;
    localparam int COLS_B    = 3;
    localparam int A_COUNT   = ROWS_A * INNER_DIM;
    localparam int B_COUNT   = INNER_DIM * COLS_B;
    localparam int LOAD_LEN  = A_COUNT + B_COUNT;
    localparam int IDLE_PCT  = 26;
    localparam int MAX_SHOWN = 10;
    localparam int HOLD_LEN  = 500;

    typedef logic signed [smm_pkg::DATA_W-1:0] element_t;

    typedef struct {
        logic signed [smm_pkg::ACC_W-1:0] product;
        logic [smm_pkg::IDX_W-1:0]        row;
        logic [smm_pkg::IDX_W-1:0]        col;
        logic                             last;
    } product_t;

    logic                             aclk            = 1'b0;
    logic                             aresetn         = 1'b0;
    logic                             s_valid         = 1'b0;
    logic                             s_ready;
    element_t                         s_element_value = '0;
    logic                             m_valid;
    logic                             m_ready         = 1'b0;
    logic signed [smm_pkg::ACC_W-1:0] m_product_value;
    logic [smm_pkg::IDX_W-1:0]        m_out_row;
    logic [smm_pkg::IDX_W-1:0]        m_out_col;
    logic                             m_last_result;

    element_t a_matrix [A_COUNT];
    element_t b_matrix [B_COUNT];
    int       load_pos        = 0;
    product_t product_q [$];

    int mismatches      = 0;
    int products_seen   = 0;
    int elements_sent   = 0;
    int matrices_loaded = 0;
    bit tx_idle_on      = 1'b1;
    bit rx_idle_on      = 1'b1;
    int rx_hold_cycles  = 0;

    small_matrix_multiply_top #(
        .ROWS_A   (ROWS_A),
        .INNER_DIM(INNER_DIM),
        .COLS_B   (COLS_B)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_element_value(s_element_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_product_value(m_product_value),
        .m_out_row      (m_out_row),
        .m_out_col      (m_out_col),
        .m_last_result  (m_last_result)
    );

    always #6 aclk = ~aclk;

    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("ERROR: %s", msg);
        end
    endfunction

    // store the element; on the last element of B queue the whole product matrix
    function automatic void absorb_element(element_t v);
        product_t                         p;
        logic signed [smm_pkg::ACC_W-1:0] sum;
        logic signed [smm_pkg::ACC_W-1:0] term;
        if (load_pos < A_COUNT) begin
            a_matrix[load_pos] = v;
        end else begin
            b_matrix[load_pos - A_COUNT] = v;
        end
        load_pos++;
        if (load_pos < LOAD_LEN) begin
            return;
        end
        load_pos = 0;
        matrices_loaded++;
        for (int r = 0; r < ROWS_A; r++) begin
            for (int c = 0; c < COLS_B; c++) begin
                sum = '0;
                for (int k = 0; k < INNER_DIM; k++) begin
                    term = a_matrix[r * INNER_DIM + k] * b_matrix[k * COLS_B + c];
                    sum  = sum + term;
                end
                p.product = sum;
                p.row     = r[smm_pkg::IDX_W-1:0];
                p.col     = c[smm_pkg::IDX_W-1:0];
                p.last    = (r == ROWS_A - 1) && (c == COLS_B - 1);
                product_q.push_back(p);
            end
        end
    endfunction

    function automatic element_t random_element();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) begin
            return element_t'($urandom);
        end
        if (pick < 8) begin
            return element_t'($urandom_range(512) - 256);
        end
        if (pick == 8) begin
            return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        end
        return element_t'($urandom_range(2) - 1);
    endfunction

    task automatic send_element(element_t v);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_element_value <= v;
        do @(posedge aclk); while (!s_ready);
        absorb_element(v);
        elements_sent++;
    endtask

    task automatic send_random_matrices(int count);
        for (int n = 0; n < count * LOAD_LEN; n++) begin
            send_element(random_element());
        end
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (product_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // full-scale positive and negative rows, a zero row and a +/-1 row against full-scale columns and a -1/256 column
    task automatic test_extreme_values();
        element_t v;
        for (int r = 0; r < ROWS_A; r++) begin
            for (int k = 0; k < INNER_DIM; k++) begin
                case (r)
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7FFF;
                    2:       v = 16'sh0000;
                    default: v = (k % 2) ? -16'sd1 : 16'sd1;
                endcase
                send_element(v);
            end
        end
        for (int k = 0; k < INNER_DIM; k++) begin
            for (int c = 0; c < COLS_B; c++) begin
                case (c)
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7FFF;
                    default: v = (k % 2) ? -16'sd1 : 16'sh0100;
                endcase
                send_element(v);
            end
        end
    endtask

    task automatic test_random_traffic();
        send_random_matrices(3);
    endtask

    task automatic test_steady_stream();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random_matrices(1);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // hold off the result side so the next load stalls on s_ready
    task automatic test_output_backpressure();
        rx_hold_cycles = HOLD_LEN;
        send_random_matrices(2);
    endtask

    task automatic test_drain_pause();
        wait_for_drain();
        send_random_matrices(1);
        wait_for_drain();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold_cycles > 0) begin
            m_ready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            m_ready <= !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        product_t want;
        if (aresetn && m_valid && m_ready) begin
            products_seen++;
            if (product_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected product row %0d col %0d value %0d last %0b",
                    m_out_row, m_out_col, m_product_value, m_last_result));
            end else begin
                want = product_q.pop_front();
                if (m_product_value !== want.product || m_out_row !== want.row ||
                    m_out_col !== want.col || m_last_result !== want.last) begin
                    flag_mismatch($sformatf(
                        "expected row %0d col %0d value %0d last %0b, got row %0d col %0d value %0d last %0b",
                        want.row, want.col, want.product, want.last,
                        m_out_row, m_out_col, m_product_value, m_last_result));
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extreme_values();
        test_random_traffic();
        test_output_backpressure();
        test_drain_pause();
        test_steady_stream();
        wait_for_drain();
        repeat (8 * INNER_DIM) @(posedge aclk);
        $display("Loaded %0d matrix pairs (%0d elements) with idling, a %0d-cycle output stall",
            matrices_loaded, elements_sent, HOLD_LEN);
        $display("and a full drain pause; %0d products checked, %0d mismatches.",
            products_seen, mismatches);
        if (mismatches == 0 && product_q.size() == 0) begin
            $display("small_matrix_multiply_top: match");
        end else begin
            $display("small_matrix_multiply_top: mismatch");
        end
        $finish;
    end

    initial begin
        #(12 * 200000);
        $display("Timeout with %0d products still expected.", product_q.size());
        $display("small_matrix_multiply_top: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/smm_pkg.sv
src/smm_mem.sv
src/smm_mac.sv
src/small_matrix_multiply_top.sv
verif/testbench.sv
